[src/sqf_pkg.sv]
// ----------------------------------------------------------------------------
// SQUFOF factorizer package
// Shared types and constants for the square-forms factorizer.
// ----------------------------------------------------------------------------
package sqf_pkg;

    localparam int DIV_W   = 64;
    localparam int DVS_W   = 32;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int Q_ENT_W = 17;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_QOVF  = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    localparam logic [1:0] REG_FWD_LIMIT   = 2'd0;
    localparam logic [1:0] REG_REV_LIMIT   = 2'd1;
    localparam logic [1:0] REG_QUEUE_LIMIT = 2'd2;

    localparam logic [19:0] FWD_LIMIT_RST   = 20'd800000;
    localparam logic [15:0] REV_LIMIT_RST   = 16'd40000;
    localparam logic [7:0]  QUEUE_LIMIT_RST = 8'd100;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

[src/squfof_integer_factorizer_top.sv]
// ----------------------------------------------------------------------------
// SQUFOF integer factorizer
// Factors one odd composite number per command by Shanks' square forms.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the single result is shown for one cycle with done high, and the
// result cannot be held off. A perfect square ends once its square root is
// checked; otherwise each forward or reverse form step runs the divider
// followed by two passes through the shared multiplier, every even forward
// step adds a pass through the square-root unit, and each square q found
// adds a search of the queued entries through the RAM read port. The number
// of steps grows roughly as the fourth root of the input.
module squfof_integer_factorizer_top #(
    parameter int QUEUE_DEPTH = 128,
    parameter int NUM_WIDTH   = 60
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] number_in,
    output logic                 busy,
    output logic                 done,
    output logic [1:0]           status,
    output logic [30:0]          factor_a,
    output logic [NUM_WIDTH-1:0] factor_b,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sqf_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LCW = (CW > 8) ? CW : 8;

    typedef enum logic [23:0] {
        ST_IDLE     = 24'h000001,
        ST_ROOT_N   = 24'h000002,
        ST_SQ_W     = 24'h000004,
        ST_SQ_CHK   = 24'h000008,
        ST_ROOT_L   = 24'h000010,
        ST_FWD_TOP  = 24'h000020,
        ST_STEP_DIV = 24'h000040,
        ST_STEP_M1W = 24'h000080,
        ST_STEP_M1  = 24'h000100,
        ST_STEP_M2W = 24'h000200,
        ST_STEP_M2  = 24'h000400,
        ST_FWD_RT   = 24'h000800,
        ST_RR_W     = 24'h001000,
        ST_RR       = 24'h002000,
        ST_SCAN     = 24'h004000,
        ST_SCAN_CHK = 24'h008000,
        ST_RI_D1    = 24'h010000,
        ST_RI_M1W   = 24'h020000,
        ST_RI_M1    = 24'h040000,
        ST_RI_M2W   = 24'h080000,
        ST_RI_M2    = 24'h100000,
        ST_RI_D2    = 24'h200000,
        ST_REV_TOP  = 24'h400000,
        ST_FIN_D    = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] fwd_limit_reg, fwd_limit_next;
    logic [15:0] rev_limit_reg, rev_limit_next;
    logic [7:0]  queue_limit_reg, queue_limit_next;

    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [30:0]          fa_reg, fa_next;
    logic [NUM_WIDTH-1:0] fb_reg, fb_next;

    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [30:0] s_reg, s_next;
    logic [30:0] p_reg, p_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] ql_reg, ql_next;
    logic [16:0] ll_reg, ll_next;
    logic [15:0] l2_reg, l2_next;
    logic [31:0] iq_reg, iq_next;
    logic [30:0] pn_reg, pn_next;
    logic        dneg_reg, dneg_next;
    logic        sign_reg, sign_next;
    logic [15:0] r_reg, r_next;
    logic [19:0] j_reg, j_next;
    logic [17:0] k_reg, k_next;
    logic        rev_reg, rev_next;
    logic [CW-1:0] qc_reg, qc_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic [31:0] mul_a_reg, mul_a_next;
    logic [31:0] mul_b_reg, mul_b_next;
    logic [63:0] prod_reg;

    div_req_t  div_req_reg, div_req_next;
    div_rsp_t  div_rsp;
    sqrt_req_t sq_req_reg, sq_req_next;
    sqrt_rsp_t sq_rsp;

    logic               ram_we;
    logic [Q_ENT_W-1:0] ram_wdata;
    logic [Q_ENT_W-1:0] ram_rdata;

    logic        cfg_wr;
    logic        q_full;
    logic        push_req;
    logic [33:0] pn_s;
    logic [30:0] ad;
    logic        over;
    logic [64:0] t_s;
    logic [31:0] qf;
    logic [30:0] diff_mag;
    logic [33:0] pnew_s;
    logic [64:0] v_s;
    logic [64:0] v_neg;
    logic        ri_ok;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign q_full = (LCW'(qc_reg) >= LCW'(queue_limit_reg))
                 || (qc_reg == CW'(QUEUE_DEPTH));
    assign push_req = (q_reg <= 32'(ll_reg))
                   && (!q_reg[0] || (q_reg <= 32'(l2_reg)));
    assign ram_wdata = q_reg[0] ? q_reg[Q_ENT_W-1:0] : q_reg[Q_ENT_W:1];

    assign pn_s = 34'(prod_reg[32:0]) - 34'(p_reg);
    assign ad   = (pn_s[30:0] > p_reg) ? pn_s[30:0] - p_reg : p_reg - pn_s[30:0];
    assign over = prod_reg > 64'h4000_0000_0000_0000;
    assign t_s  = dneg_reg ? 65'(ql_reg) - 65'(prod_reg) : 65'(ql_reg) + 65'(prod_reg);
    assign qf   = q_reg[0] ? q_reg : (q_reg >> 1);
    assign diff_mag = (p_reg > s_reg) ? p_reg - s_reg : s_reg - p_reg;
    assign pnew_s = sign_reg ? 34'(p_reg) - 34'(prod_reg[32:0])
                             : 34'(p_reg) + 34'(prod_reg[32:0]);
    assign v_s   = 65'(n_reg) - 65'(prod_reg);
    assign v_neg = 65'(0) - v_s;
    assign ri_ok = !sign_reg && (div_rsp.quotient[63:32] == 32'd0)
                && (div_rsp.quotient[31:0] != 32'd0);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FWD_LIMIT:   prdata = 32'(fwd_limit_reg);
            REG_REV_LIMIT:   prdata = 32'(rev_limit_reg);
            REG_QUEUE_LIMIT: prdata = 32'(queue_limit_reg);
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        fwd_limit_next   = fwd_limit_reg;
        rev_limit_next   = rev_limit_reg;
        queue_limit_next = queue_limit_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FWD_LIMIT:   fwd_limit_next   = pwdata[19:0];
                REG_REV_LIMIT:   rev_limit_next   = pwdata[15:0];
                REG_QUEUE_LIMIT: queue_limit_next = pwdata[7:0];
                default:         fwd_limit_next   = fwd_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        n_next      = n_reg;
        s_next      = s_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        ql_next     = ql_reg;
        ll_next     = ll_reg;
        l2_next     = l2_reg;
        iq_next     = iq_reg;
        pn_next     = pn_reg;
        dneg_next   = dneg_reg;
        sign_next   = sign_reg;
        r_next      = r_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        rev_next    = rev_reg;
        qc_next     = qc_reg;
        idx_next    = idx_reg;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        div_req_next       = div_req_reg;
        div_req_next.start = 1'b0;
        sq_req_next        = sq_req_reg;
        sq_req_next.start  = 1'b0;
        ram_we = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next   = number_in;
                    qc_next  = '0;
                    j_next   = '0;
                    rev_next = 1'b0;
                    sq_req_next.start    = 1'b1;
                    sq_req_next.radicand = SQ_W'(number_in);
                    state_next = ST_ROOT_N;
                end
            end
            ST_ROOT_N:
            begin
                if (sq_rsp.done)
                begin
                    s_next     = sq_rsp.root[30:0];
                    mul_a_next = 32'(sq_rsp.root[30:0]);
                    mul_b_next = 32'(sq_rsp.root[30:0]);
                    state_next = ST_SQ_W;
                end
            end
            ST_SQ_W:
            begin
                state_next = ST_SQ_CHK;
            end
            ST_SQ_CHK:
            begin
                if (prod_reg == 64'(n_reg))
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    fa_next     = s_reg;
                    fb_next     = NUM_WIDTH'(s_reg);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    p_next  = s_reg;
                    q_next  = 32'(64'(n_reg) - prod_reg);
                    ql_next = 32'd1;
                    sq_req_next.start    = 1'b1;
                    sq_req_next.radicand = SQ_W'({s_reg, 1'b0});
                    state_next = ST_ROOT_L;
                end
            end
            ST_ROOT_L:
            begin
                if (sq_rsp.done)
                begin
                    ll_next    = {sq_rsp.root[15:0], 1'b1};
                    l2_next    = sq_rsp.root[15:0];
                    state_next = ST_FWD_TOP;
                end
            end
            ST_FWD_TOP:
            begin
                if (j_reg >= fwd_limit_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else if (push_req && q_full)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_QOVF;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if (push_req)
                    begin
                        ram_we  = 1'b1;
                        qc_next = qc_reg + 1'b1;
                    end
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_W'(s_reg) + DIV_W'(p_reg);
                    div_req_next.divisor  = q_reg;
                    state_next = ST_STEP_DIV;
                end
            end
            ST_REV_TOP:
            begin
                if (k_reg >= {rev_limit_reg, 2'b00})
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_W'(s_reg) + DIV_W'(p_reg);
                    div_req_next.divisor  = q_reg;
                    state_next = ST_STEP_DIV;
                end
            end
            ST_STEP_DIV:
            begin
                if (div_rsp.done)
                begin
                    iq_next    = div_rsp.quotient[31:0];
                    mul_a_next = div_rsp.quotient[31:0];
                    mul_b_next = q_reg;
                    state_next = ST_STEP_M1W;
                end
            end
            ST_STEP_M1W:
            begin
                state_next = ST_STEP_M1;
            end
            ST_STEP_M1:
            begin
                if (rev_reg && (pn_s == 34'(p_reg)))
                begin
                    if (qf[31])
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_LIMIT;
                        fa_next     = '0;
                        fb_next     = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        iq_next = qf;
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = DIV_W'(n_reg);
                        div_req_next.divisor  = qf;
                        state_next = ST_FIN_D;
                    end
                end
                else if (pn_s[33:31] != 3'd0)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    pn_next    = pn_s[30:0];
                    dneg_next  = pn_s[30:0] > p_reg;
                    mul_a_next = iq_reg;
                    mul_b_next = 32'(ad);
                    state_next = ST_STEP_M2W;
                end
            end
            ST_STEP_M2W:
            begin
                state_next = ST_STEP_M2;
            end
            ST_STEP_M2:
            begin
                if (over || (t_s[64:32] != 33'd0) || (t_s[31:0] == 32'd0))
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ql_next = q_reg;
                    q_next  = t_s[31:0];
                    p_next  = pn_reg;
                    if (rev_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_REV_TOP;
                    end
                    else if (j_reg[0])
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_FWD_TOP;
                    end
                    else
                    begin
                        sq_req_next.start    = 1'b1;
                        sq_req_next.radicand = SQ_W'(t_s[31:0]);
                        state_next = ST_FWD_RT;
                    end
                end
            end
            ST_FWD_RT:
            begin
                if (sq_rsp.done)
                begin
                    r_next     = sq_rsp.root[15:0];
                    mul_a_next = 32'(sq_rsp.root[15:0]);
                    mul_b_next = 32'(sq_rsp.root[15:0]);
                    state_next = ST_RR_W;
                end
            end
            ST_RR_W:
            begin
                state_next = ST_RR;
            end
            ST_RR:
            begin
                if (prod_reg != 64'(q_reg))
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FWD_TOP;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == qc_reg)
                begin
                    sign_next = p_reg > s_reg;
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_W'(diff_mag);
                    div_req_next.divisor  = 32'(r_reg);
                    state_next = ST_RI_D1;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (ram_rdata == Q_ENT_W'(r_reg))
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FWD_TOP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_RI_D1:
            begin
                if (div_rsp.done)
                begin
                    mul_a_next = 32'(r_reg);
                    mul_b_next = div_rsp.quotient[31:0];
                    state_next = ST_RI_M1W;
                end
            end
            ST_RI_M1W:
            begin
                state_next = ST_RI_M1;
            end
            ST_RI_M1:
            begin
                if (pnew_s[33:31] != 3'd0)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    fa_next     = '0;
                    fb_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    p_next     = pnew_s[30:0];
                    ql_next    = 32'(r_reg);
                    mul_a_next = 32'(pnew_s[30:0]);
                    mul_b_next = 32'(pnew_s[30:0]);
                    state_next = ST_RI_M2W;
                end
            end
            ST_RI_M2W:
            begin
                state_next = ST_RI_M2;
            end
            ST_RI_M2:
            begin
                sign_next = v_s[64];
                div_req_next.start    = 1'b1;
                div_req_next.dividend = v_s[64] ? v_neg[63:0] : v_s[63:0];
                div_req_next.divisor  = 32'(r_reg);
                state_next = ST_RI_D2;
            end
            ST_RI_D2:
            begin
                if (div_rsp.done)
                begin
                    if (!ri_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_LIMIT;
                        fa_next     = '0;
                        fb_next     = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        q_next     = div_rsp.quotient[31:0];
                        k_next     = '0;
                        rev_next   = 1'b1;
                        state_next = ST_REV_TOP;
                    end
                end
            end
            ST_FIN_D:
            begin
                if (div_rsp.done)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    fa_next     = iq_reg[30:0];
                    fb_next     = div_rsp.quotient[NUM_WIDTH-1:0];
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            fwd_limit_reg   <= FWD_LIMIT_RST;
            rev_limit_reg   <= REV_LIMIT_RST;
            queue_limit_reg <= QUEUE_LIMIT_RST;
            j_reg           <= '0;
            k_reg           <= '0;
            rev_reg         <= 1'b0;
            qc_reg          <= '0;
            idx_reg         <= '0;
            div_req_reg     <= '0;
            sq_req_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            fwd_limit_reg   <= fwd_limit_next;
            rev_limit_reg   <= rev_limit_next;
            queue_limit_reg <= queue_limit_next;
            j_reg           <= j_next;
            k_reg           <= k_next;
            rev_reg         <= rev_next;
            qc_reg          <= qc_next;
            idx_reg         <= idx_next;
            div_req_reg     <= div_req_next;
            sq_req_reg      <= sq_req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        n_reg      <= n_next;
        s_reg      <= s_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        ql_reg     <= ql_next;
        ll_reg     <= ll_next;
        l2_reg     <= l2_next;
        iq_reg     <= iq_next;
        pn_reg     <= pn_next;
        dneg_reg   <= dneg_next;
        sign_reg   <= sign_next;
        r_reg      <= r_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        prod_reg   <= 64'(mul_a_reg) * 64'(mul_b_reg);
    end

    sqf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    sqf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req_reg),
        .rsp   (sq_rsp)
    );

    sqf_ram #(
        .WIDTH (Q_ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (qc_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign factor_a = fa_reg;
    assign factor_b = fb_reg;

endmodule

[src/sqf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sqf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/sqf_div.sv]
// ----------------------------------------------------------------------------
// SQUFOF divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sqf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sqf_pkg::div_req_t req,
    output sqf_pkg::div_rsp_t rsp
);
    import sqf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[src/sqf_isqrt.sv]
// ----------------------------------------------------------------------------
// SQUFOF integer square root
// Exact floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sqf_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  sqf_pkg::sqrt_req_t req,
    output sqf_pkg::sqrt_rsp_t rsp
);
    import sqf_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [SQ_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            v_next    = req.radicand;
            res_next  = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule

[src/sqf_checker.sv]
// ----------------------------------------------------------------------------
// SQUFOF factorizer checker
// Port-level assertions on command and result beats and on pready, bound to the top level.
// ----------------------------------------------------------------------------
module sqf_checker #(
    parameter int NUM_WIDTH = 60
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [1:0]           status,
    input logic [30:0]          factor_a,
    input logic [NUM_WIDTH-1:0] factor_b,
    input logic                 pready
);
    import sqf_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("command beat did not raise busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> ((factor_a == 31'd0) && (factor_b == '0)))
        else $error("failure beat carries nonzero factors");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == STAT_OK) || (status == STAT_QOVF) || (status == STAT_LIMIT)))
        else $error("result beat with undefined status");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind squfof_integer_factorizer_top sqf_checker #(.NUM_WIDTH(NUM_WIDTH)) u_sqf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .factor_a (factor_a),
    .factor_b (factor_b),
    .pready   (pready)
);
